[sv/nsr_pkg.sv]
// Shared widths, codes, control types and helpers for the Newton square-root block.
package nsr_pkg;

  localparam int WORD_W = 32;
  localparam int SQ_W = 2 * WORD_W;
  localparam int DEN_W = WORD_W + 1;
  localparam int STEP_W = 7;
  localparam int IDX_W = 2;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(64);
  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef enum logic [IDX_W-1:0] {
    CFG_FIRST_GUESS = 2'd0,
    CFG_TOLERANCE   = 2'd1,
    CFG_ITER_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic div_init;
    logic update;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first_step;
    logic above;
    logic at_limit;
    logic div_done;
  } ctrl_sts_t;

  // A limit of zero runs one step; anything beyond the cap runs the cap.
  function automatic logic [STEP_W-1:0] clamp_limit(input logic [STEP_W-1:0] lim);
    logic [STEP_W-1:0] res;
    res = lim;
    if (lim == '0) begin
      res = STEP_W'(1);
    end else if (lim > STEP_CAP) begin
      res = STEP_CAP;
    end
    return res;
  endfunction

endpackage

[sv/nsr_intf.sv]
// Handshake channel interfaces for input items, results and configuration writes.
interface nsr_in_if;
  logic                       valid;
  logic                       ready;
  logic [nsr_pkg::WORD_W-1:0] radicand;
  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface nsr_out_if;
  logic                       valid;
  logic                       ready;
  logic [nsr_pkg::WORD_W-1:0] root;
  logic [nsr_pkg::STEP_W-1:0] steps_taken;
  logic                       limit_hit;
  modport source (output valid, output root, output steps_taken, output limit_hit,
                  input ready);
  modport sink (input valid, input root, input steps_taken, input limit_hit,
                output ready);
endinterface

interface nsr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nsr_pkg::IDX_W-1:0]  index;
  logic [nsr_pkg::WORD_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/nsr_div.sv]
// Restoring radix-2 divider producing one quotient bit per cycle.
module nsr_div #(
  parameter int QUOT_W = nsr_pkg::WORD_W + nsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nsr_pkg::SQ_W-1:0]    dividend,
  input  logic [nsr_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [QUOT_W-1:0]           quotient
);
  import nsr_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUOT_W-1:0] sh_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_diff;
  logic              fits;
  logic [DEN_W-1:0]  rem_nxt;

  // The quotient is known to fit in QUOT_W bits, so the top of the dividend
  // is already below the divisor and seeds the partial remainder directly.
  assign trial      = {rem_r, sh_r[QUOT_W-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign fits       = (trial >= {1'b0, den_r});
  assign rem_nxt    = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(dividend[SQ_W-1:QUOT_W]);
      sh_r  <= dividend[QUOT_W-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[QUOT_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

[sv/nsr_dpath.sv]
// Datapath: estimate, squaring, residual, division and estimate update.
module nsr_dpath #(
  parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nsr_pkg::ctrl_cmd_t            cmd,
  output nsr_pkg::ctrl_sts_t            sts,
  input  logic [nsr_pkg::WORD_W-1:0]    radicand,
  input  logic [nsr_pkg::WORD_W-1:0]    first_guess,
  input  logic [nsr_pkg::WORD_W-1:0]    tolerance,
  input  logic [nsr_pkg::STEP_W-1:0]    iteration_limit,
  output logic [nsr_pkg::WORD_W-1:0]    root,
  output logic [nsr_pkg::STEP_W-1:0]    steps
);
  import nsr_pkg::*;

  localparam int A_W    = WORD_W + FRACTION_BITS;
  localparam int QUOT_W = WORD_W + FRACTION_BITS;
  localparam int SUM_W  = QUOT_W + 1;

  logic [WORD_W-1:0] x_r;
  logic [A_W-1:0]    a_r;
  logic [SQ_W-1:0]   sq_r;
  logic [STEP_W-1:0] steps_r;
  logic [STEP_W-1:0] limit_r;
  logic              neg_r;

  logic [SQ_W-1:0]   a_ext;
  logic              sq_ge;
  logic [SQ_W-1:0]   res_up;
  logic [SQ_W-1:0]   res_dn;
  logic [SQ_W-1:0]   residual;
  logic              div_done;
  logic [QUOT_W-1:0] quot;
  logic [SUM_W-1:0]  x_sum;
  logic [WORD_W-1:0] x_nxt;

  assign a_ext    = SQ_W'(a_r);
  assign sq_ge    = (sq_r >= a_ext);
  assign res_up   = sq_r - a_ext;
  assign res_dn   = a_ext - sq_r;
  assign residual = sq_ge ? res_up : res_dn;

  nsr_div #(.QUOT_W(QUOT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_init),
    .dividend (residual),
    .divisor  ({x_r, 1'b0}),
    .done     (div_done),
    .quotient (quot)
  );

  // Subtracting never goes below zero: the quotient is at most half of x.
  always_comb begin
    if (neg_r) begin
      x_sum = SUM_W'(x_r) - SUM_W'(quot);
    end else begin
      x_sum = SUM_W'(x_r) + SUM_W'(quot);
    end
    if (|x_sum[SUM_W-1:WORD_W]) begin
      x_nxt = WORD_MAX;
    end else if (x_sum == '0) begin
      x_nxt = WORD_W'(1);
    end else begin
      x_nxt = x_sum[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
    end else if (cmd.load) begin
      steps_r <= '0;
    end else if (cmd.update) begin
      steps_r <= steps_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= (first_guess == '0) ? WORD_W'(1) : first_guess;
      a_r     <= {radicand, FRACTION_BITS'(0)};
      limit_r <= clamp_limit(iteration_limit);
    end else if (cmd.update) begin
      x_r <= x_nxt;
    end
    if (cmd.square) begin
      sq_r <= x_r * x_r;
    end
    if (cmd.div_init) begin
      neg_r <= sq_ge;
    end
  end

  assign sts.first_step = (steps_r == '0);
  assign sts.above      = sq_ge && (res_up > SQ_W'(tolerance));
  assign sts.at_limit   = (steps_r >= limit_r);
  assign sts.div_done   = div_done;

  assign root  = x_r;
  assign steps = steps_r;

endmodule

[sv/nsr_ctrl.sv]
// Controller state machine sequencing the Newton steps of one item.
module nsr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_free,
  input  nsr_pkg::ctrl_sts_t sts,
  output nsr_pkg::ctrl_cmd_t cmd
);
  import nsr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   go_on;

  // The first step always runs; later ones only while the residual is too
  // large and the limit has not been reached.
  assign go_on = sts.first_step || (sts.above && !sts.at_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQUARE;
      end
      ST_SQUARE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = go_on ? ST_DIVIDE : ST_FINISH;
      end
      ST_DIVIDE: begin
        if (sts.div_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_SQUARE;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQUARE: cmd.square = 1'b1;
      ST_CHECK:  cmd.div_init = go_on;
      ST_DIVIDE: ;
      ST_UPDATE: cmd.update = 1'b1;
      ST_FINISH: cmd.finish = out_free;
      default: ;
    endcase
  end

endmodule

[sv/newton_square_root.sv]
// Top level of the Newton-Raphson square-root block with configuration and result register.
//
// Usage: each transfer on in_chan carries one unsigned Q16.16 radicand; each
// transfer on out_chan returns its root (Q16.16, saturated), the number of
// Newton steps taken and a flag that is set when the iteration limit rather
// than the tolerance ended the loop. Exactly one result follows each input.
// cfg_chan writes first_guess, tolerance and iteration_limit by index; it is
// always ready, and writes should only be made while no item is in flight.
// Each Newton step squares the estimate, checks the residual, runs the
// one-bit-per-cycle divider (32 + FRACTION_BITS quotient bits) and
// updates the estimate. One item is worked on at a time.
// Reset: synchronous, active low; the registers return to a first guess of
// 2.0, a tolerance of about 1e-4 and a limit of 32 steps, and no result is held.
// Stalls: a finished result waits in the output register, so the next item
// can be accepted and worked on; only when a new result is ready while the
// old one is still untaken does the block wait.
module newton_square_root #(
  parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nsr_in_if.sink     in_chan,
  nsr_out_if.source  out_chan,
  nsr_cfg_if.sink    cfg_chan
);
  import nsr_pkg::*;

  // Reset values follow the fraction width: 2.0 and round(1e-4 * 2^(2F)),
  // the latter saturated to the register width.
  localparam logic [WORD_W-1:0] FG_RST   = WORD_W'(2) << FRACTION_BITS;
  localparam logic [SQ_W-1:0]   TOL_FULL =
    ((SQ_W'(1) << (2 * FRACTION_BITS)) + SQ_W'(5000)) / SQ_W'(10000);
  localparam logic [WORD_W-1:0] TOL_RST  =
    (TOL_FULL > SQ_W'(WORD_MAX)) ? WORD_MAX : TOL_FULL[WORD_W-1:0];
  localparam logic [STEP_W-1:0] LIM_RST  = STEP_W'(32);

  logic [WORD_W-1:0] first_guess_r;
  logic [WORD_W-1:0] tolerance_r;
  logic [STEP_W-1:0] iter_limit_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] root_r;
  logic [STEP_W-1:0] steps_r;
  logic              hit_r;

  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;
  logic              out_free;
  logic [WORD_W-1:0] dp_root;
  logic [STEP_W-1:0] dp_steps;

  // Configuration registers: every write transfer is taken at once; an
  // index beyond the register list is ignored.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_guess_r <= FG_RST;
      tolerance_r   <= TOL_RST;
      iter_limit_r  <= LIM_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_FIRST_GUESS: first_guess_r <= cfg_chan.data;
        CFG_TOLERANCE:   tolerance_r   <= cfg_chan.data;
        CFG_ITER_LIMIT:  iter_limit_r  <= cfg_chan.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_r || out_chan.ready;

  nsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  nsr_dpath #(.FRACTION_BITS(FRACTION_BITS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .radicand        (in_chan.radicand),
    .first_guess     (first_guess_r),
    .tolerance       (tolerance_r),
    .iteration_limit (iter_limit_r),
    .root            (dp_root),
    .steps           (dp_steps)
  );

  // Result register. At finish the residual check of the last step is still
  // on the status lines, so "above" tells whether the limit stopped the loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      root_r  <= dp_root;
      steps_r <= dp_steps;
      hit_r   <= sts.above;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.root        = root_r;
  assign out_chan.steps_taken = steps_r;
  assign out_chan.limit_hit   = hit_r;

`ifndef SYNTHESIS
  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (steps_r != '0) && (steps_r <= STEP_CAP))
    else $error("result step count out of range");

  a_limit_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hit_r) |-> (steps_r == clamp_limit(iter_limit_r)))
    else $error("limit flag set without reaching the step limit");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (root_r != '0))
    else $error("zero root delivered");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !cmd.finish)
    else $error("pending result overwritten");
`endif

endmodule
